/* design/rla_pkg.sv */
package rla_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 32;

  localparam logic [7:0] BUG_STATUS_RST  = 8'd66;
  localparam logic [7:0] OVF_REASON_RST  = 8'd0;
  localparam logic [7:0] UNINIT_REASON_RST = 8'd0;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  localparam logic [2:0]  DIGIT_UNITS = 3'd4;
  localparam logic [15:0] DEC_WEIGHT [4] = '{16'd10000, 16'd1000, 16'd100, 16'd10};

  localparam logic [1:0] REG_BUG_STATUS    = 2'd0;
  localparam logic [1:0] REG_OVF_REASON    = 2'd1;
  localparam logic [1:0] REG_UNINIT_REASON = 2'd2;

  typedef enum logic [1:0] {
    FUNC_SET_STATUS  = 2'd0,
    FUNC_APPEND_BYTE = 2'd1,
    FUNC_APPEND_NUM  = 2'd2,
    FUNC_SEND        = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRESH,
    ST_EXEC,
    ST_DIGIT,
    ST_GT,
    ST_STAT,
    ST_PAYLOAD,
    ST_CR,
    ST_LF
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_GT,
    EMIT_STATUS,
    EMIT_PAYLOAD,
    EMIT_CR,
    EMIT_LF
  } emit_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  status_code;
    logic        has_reason;
    logic [7:0]  reason_code;
    logic [7:0]  char_value;
    logic [15:0] number;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic [7:0] bug_status;
    logic [7:0] ovf_reason;
    logic [7:0] uninit_reason;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  leave_fresh;
    logic  exec;
    logic  digit;
    emit_e emit;
    logic  idx_clr;
    logic  idx_inc;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  fresh;
    logic  digit_done;
    logic  payload_empty;
    logic  idx_last;
  } stat_t;

endpackage

/* design/rla_ram.sv */
module rla_ram import rla_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rla_ctrl.sv */
module rla_ctrl import rla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  func_e func_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_SEND) begin
            state_d = ST_GT;
          end else if (stat_i.fresh) begin
            state_d = ST_FRESH;
          end else if (func_i == FUNC_APPEND_NUM) begin
            state_d = ST_DIGIT;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_FRESH: begin
        state_d = (stat_i.func == FUNC_APPEND_NUM) ? ST_DIGIT : ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      ST_DIGIT: begin
        if (stat_i.digit_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_GT:   state_d = ST_STAT;
      ST_STAT: state_d = stat_i.payload_empty ? ST_CR : ST_PAYLOAD;
      ST_PAYLOAD: begin
        if (stat_i.idx_last) begin
          state_d = ST_CR;
        end
      end
      ST_CR:   state_d = ST_LF;
      ST_LF:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.emit = EMIT_NONE;
    unique case (state_q)
      ST_IDLE:  cmd_o.load = start_i;
      ST_FRESH: cmd_o.leave_fresh = 1'b1;
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_DIGIT: cmd_o.digit = 1'b1;
      ST_GT: begin
        cmd_o.emit    = EMIT_GT;
        cmd_o.idx_clr = 1'b1;
      end
      ST_STAT: cmd_o.emit = EMIT_STATUS;
      ST_PAYLOAD: begin
        cmd_o.emit    = EMIT_PAYLOAD;
        cmd_o.idx_inc = 1'b1;
      end
      ST_CR:   cmd_o.emit = EMIT_CR;
      ST_LF:   cmd_o.emit = EMIT_LF;
      default: cmd_o.emit = EMIT_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* design/rla_datapath.sv */
module rla_datapath import rla_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output result_t result_o,
  output logic    result_strobe_o
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned LW = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(PAYLOAD_DEPTH);

  item_t       item_q, item_d;
  logic [15:0] v_q, v_d;
  logic [2:0]  k_q, k_d;
  logic [3:0]  d_q, d_d;
  logic        started_q, started_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  slot0_q, slot0_d;
  logic [LW-1:0] len_q, len_d;
  logic        fresh_q, fresh_d;
  logic [AW-1:0] idx_q, idx_d;
  result_t     res_q, res_d;
  logic        strobe_q, strobe_d;

  logic          push_en;
  logic [7:0]    push_byte;
  logic [LW-1:0] len_base;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [LW-1:0] idx_nxt;
  logic [15:0]   weight;
  logic          ge_weight;

  assign idx_nxt   = LW'(idx_q) + LW'(1);
  assign ram_raddr = (idx_nxt < DEPTH_L) ? idx_nxt[AW-1:0] : '0;
  assign weight    = DEC_WEIGHT[k_q[1:0]];
  assign ge_weight = (k_q != DIGIT_UNITS) && (v_q >= weight);

  rla_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // item, digit and store updates
  always_comb begin
    item_d    = item_q;
    v_d       = v_q;
    k_d       = k_q;
    d_d       = d_q;
    started_d = started_q;
    status_d  = status_q;
    slot0_d   = slot0_q;
    len_d     = len_q;
    fresh_d   = fresh_q;
    push_en   = 1'b0;
    push_byte = item_q.char_value;
    len_base  = len_q;
    ram_we    = 1'b0;
    ram_waddr = len_base[AW-1:0];

    if (cmd_i.load) begin
      item_d    = item_i;
      v_d       = item_i.number;
      k_d       = '0;
      d_d       = '0;
      started_d = 1'b0;
    end

    if (cmd_i.leave_fresh) begin
      status_d = cfg_i.bug_status;
      slot0_d  = cfg_i.uninit_reason;
      len_d    = LW'(1);
      fresh_d  = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (item_q.func)
        FUNC_SET_STATUS: begin
          status_d  = item_q.status_code;
          len_base  = '0;
          len_d     = '0;
          push_en   = item_q.has_reason;
          push_byte = item_q.reason_code;
        end
        FUNC_APPEND_BYTE: begin
          push_en   = 1'b1;
          push_byte = item_q.char_value;
        end
        default: push_en = 1'b0;
      endcase
    end

    if (cmd_i.digit) begin
      if (ge_weight) begin
        v_d       = v_q - weight;
        d_d       = d_q + 4'd1;
        started_d = 1'b1;
      end else if (k_q == DIGIT_UNITS) begin
        push_en   = 1'b1;
        push_byte = CHAR_ZERO + {4'b0, v_q[3:0]};
      end else begin
        push_en   = started_q;
        push_byte = CHAR_ZERO + {4'b0, d_q};
        k_d       = k_q + 3'd1;
        d_d       = '0;
      end
    end

    ram_waddr = len_base[AW-1:0];
    if (push_en) begin
      if (len_base < DEPTH_L) begin
        ram_we = 1'b1;
        if (len_base == '0) begin
          slot0_d = push_byte;
        end
        len_d = len_base + LW'(1);
      end else begin
        // store full: report a bug with the overflow reason
        status_d = cfg_i.bug_status;
        slot0_d  = cfg_i.ovf_reason;
        len_d    = LW'(1);
      end
    end
  end

  // line emission
  always_comb begin
    idx_d    = idx_q;
    res_d    = res_q;
    strobe_d = (cmd_i.emit != EMIT_NONE);
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
    res_d.last_byte = 1'b0;
    case (cmd_i.emit)
      EMIT_GT:     res_d.out_byte = CHAR_GT;
      EMIT_STATUS: res_d.out_byte = fresh_q ? cfg_i.bug_status : status_q;
      EMIT_PAYLOAD: begin
        if (idx_q == '0) begin
          res_d.out_byte = fresh_q ? cfg_i.uninit_reason : slot0_q;
        end else begin
          res_d.out_byte = ram_rdata;
        end
      end
      EMIT_CR:     res_d.out_byte = CHAR_CR;
      EMIT_LF: begin
        res_d.out_byte  = CHAR_LF;
        res_d.last_byte = 1'b1;
      end
      default:     res_d.out_byte = res_q.out_byte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= 1'b1;
      len_q    <= LW'(1);
      status_q <= BUG_STATUS_RST;
      strobe_q <= 1'b0;
      k_q      <= DIGIT_UNITS;
      idx_q    <= '0;
    end else begin
      fresh_q  <= fresh_d;
      len_q    <= len_d;
      status_q <= status_d;
      strobe_q <= strobe_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    v_q       <= v_d;
    d_q       <= d_d;
    started_q <= started_d;
    slot0_q   <= slot0_d;
    res_q     <= res_d;
  end

  assign stat_o.func          = item_q.func;
  assign stat_o.fresh         = fresh_q;
  assign stat_o.digit_done    = cmd_i.digit && !ge_weight && (k_q == DIGIT_UNITS);
  assign stat_o.payload_empty = (len_q == '0);
  assign stat_o.idx_last      = (idx_nxt == len_q);

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule

/* design/response_line_assembler_unit.sv */
// Response line assembler. An item is taken when start is high and busy is low; busy then
// stays high until the item is done. Append number subtracts 10000, 1000, 100 and 10 in
// turn as often as each fits, writing one digit per position with leading zeros dropped,
// in the single shared subtract-and-compare unit; the first set or append after reset first
// passes through a state that loads the reset line. Send emits one byte per cycle, payload
// bytes after the first read from the payload RAM. Each byte of the line appears on result_o
// for exactly one cycle with result_strobe_o high, in the cycle after it is produced, with
// last_byte marking the closing LF; the receiver cannot stall and must take every transfer.
// Configuration must be written through the APB port only while idle; the block does not enforce it.
module response_line_assembler_unit import rla_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output result_t     result_o,
  output logic        result_strobe_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q, cfg_d;
  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BUG_STATUS:    cfg_d.bug_status    = pwdata[7:0];
        REG_OVF_REASON:    cfg_d.ovf_reason    = pwdata[7:0];
        REG_UNINIT_REASON: cfg_d.uninit_reason = pwdata[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BUG_STATUS:    prdata = {24'b0, cfg_q.bug_status};
      REG_OVF_REASON:    prdata = {24'b0, cfg_q.ovf_reason};
      REG_UNINIT_REASON: prdata = {24'b0, cfg_q.uninit_reason};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bug_status    <= BUG_STATUS_RST;
      cfg_q.ovf_reason    <= OVF_REASON_RST;
      cfg_q.uninit_reason <= UNINIT_REASON_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rla_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (item_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rla_datapath #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rla_pkg::*;

  localparam int unsigned DEPTH = PAYLOAD_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       item_i;
  result_t     result_o;
  logic        result_strobe_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted register and line state
  logic [7:0]  cfg_bug_status;
  logic [7:0]  cfg_ovf_reason;
  logic [7:0]  cfg_uninit_reason;
  logic [7:0]  line_status;
  logic [7:0]  line_payload [DEPTH];
  int unsigned line_len;
  bit          line_fresh;
  result_t     line_bytes_q [$];

  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en;

  response_line_assembler_unit #(
    .PAYLOAD_DEPTH(DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_line
    result_t want;
    if (rst_ni && result_strobe_o) begin
      if (line_bytes_q.size() == 0) begin
        $error("transfer with nothing pending: out_byte %h last_byte %b",
               result_o.out_byte, result_o.last_byte);
        error_cnt++;
      end else begin
        want = line_bytes_q.pop_front();
        if (result_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, result_o.out_byte);
          error_cnt++;
        end
        if (result_o.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, actual %b", want.last_byte, result_o.last_byte);
          error_cnt++;
        end
      end
    end
  end

  function automatic void queue_out(logic [7:0] b, logic last);
    result_t r;
    r.out_byte  = b;
    r.last_byte = last;
    line_bytes_q.push_back(r);
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (line_len < DEPTH) begin
      line_payload[line_len] = b;
      line_len++;
    end else begin
      // store full: report a bug line instead
      line_status     = cfg_bug_status;
      line_payload[0] = cfg_ovf_reason;
      line_len        = 1;
    end
  endfunction

  function automatic void store_number(logic [15:0] value);
    int unsigned rest;
    int unsigned scale;
    int unsigned digit;
    bit          lead;
    rest  = value;
    lead  = 1'b0;
    scale = 10000;
    while (scale > 1) begin
      digit = rest / scale;
      rest  = rest % scale;
      if (digit != 0) lead = 1'b1;
      if (lead) store_byte(CHAR_ZERO + 8'(digit));
      scale = scale / 10;
    end
    store_byte(CHAR_ZERO + 8'(rest));
  endfunction

  function automatic void assemble_item(item_t it);
    int unsigned i;
    // the first non-send item latches the reset line
    if (it.func != FUNC_SEND && line_fresh) begin
      line_status     = cfg_bug_status;
      line_payload[0] = cfg_uninit_reason;
      line_len        = 1;
      line_fresh      = 1'b0;
    end
    case (it.func)
      FUNC_SET_STATUS: begin
        line_status = it.status_code;
        line_len    = 0;
        if (it.has_reason) store_byte(it.reason_code);
      end
      FUNC_APPEND_BYTE: store_byte(it.char_value);
      FUNC_APPEND_NUM:  store_number(it.number);
      default: begin
        queue_out(CHAR_GT, 1'b0);
        queue_out(line_fresh ? cfg_bug_status : line_status, 1'b0);
        for (i = 0; i < line_len; i++) begin
          queue_out((line_fresh && i == 0) ? cfg_uninit_reason : line_payload[i], 1'b0);
        end
        queue_out(CHAR_CR, 1'b0);
        queue_out(CHAR_LF, 1'b1);
      end
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.func        = func_e'(2'($urandom_range(3)));
    it.status_code = 8'($urandom);
    it.has_reason  = 1'($urandom);
    it.reason_code = 8'($urandom);
    it.char_value  = 8'($urandom);
    it.number      = 16'($urandom);
    return it;
  endfunction

  function automatic item_t make_op(func_e f);
    item_t it;
    it      = rand_item();
    it.func = f;
    return it;
  endfunction

  // spread over digit counts so short numbers are common
  function automatic logic [15:0] rand_number();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(9));
      1:       return 16'($urandom_range(99, 10));
      2:       return 16'($urandom_range(999, 100));
      3:       return 16'($urandom_range(9999, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 20) begin
      start  = 1'b0;
      item_i = rand_item();
      @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    assemble_item(it);
  endtask

  task automatic drain_line_bytes();
    @(negedge clk_i);
    start = 1'b0;
    while (line_bytes_q.size() != 0) @(posedge clk_i);
    // set and append items leave no transfer behind, give them time to finish
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BUG_STATUS:    cfg_bug_status    = value;
      REG_OVF_REASON:    cfg_ovf_reason    = value;
      REG_UNINIT_REASON: cfg_uninit_reason = value;
      default: ;
    endcase
    // read back
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx != REG_UNMAPPED && prdata[7:0] !== value) begin
      $error("prdata: expected %h, actual %h", value, prdata[7:0]);
      error_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_lines(int n_items);
    int    done;
    int    n_app;
    item_t it;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_item(rand_item());
        done++;
      end else begin
        send_item(make_op(FUNC_SET_STATUS));
        done++;
        n_app = ($urandom_range(99) < 15) ? $urandom_range(40, 16) : $urandom_range(8);
        repeat (n_app) begin
          it        = make_op($urandom_range(1) ? FUNC_APPEND_BYTE : FUNC_APPEND_NUM);
          it.number = rand_number();
          send_item(it);
          done++;
        end
        repeat ($urandom_range(2, 1)) begin
          send_item(make_op(FUNC_SEND));
          done++;
        end
      end
    end
  endtask

  task automatic test_fresh_line();
    item_t it;
    idle_en = 1'b0;
    send_item(make_op(FUNC_SEND));
    drain_line_bytes();
    cfg_write(REG_BUG_STATUS, 8'h00);
    cfg_write(REG_UNINIT_REASON, 8'hFF);
    send_item(make_op(FUNC_SEND));
    drain_line_bytes();
    cfg_write(REG_BUG_STATUS, 8'hFF);
    cfg_write(REG_UNINIT_REASON, 8'h5A);
    it            = make_op(FUNC_APPEND_BYTE);
    it.char_value = 8'h00;
    send_item(it);
    send_item(make_op(FUNC_SEND));
  endtask

  task automatic test_each_operation();
    item_t       it;
    logic [15:0] nums [5] = '{16'd0, 16'd9, 16'd10, 16'd10000, 16'd65535};
    it             = make_op(FUNC_SET_STATUS);
    it.status_code = 8'hFF;
    it.has_reason  = 1'b1;
    it.reason_code = 8'h00;
    send_item(it);
    it            = make_op(FUNC_APPEND_BYTE);
    it.char_value = 8'hFF;
    send_item(it);
    foreach (nums[k]) begin
      it        = make_op(FUNC_APPEND_NUM);
      it.number = nums[k];
      send_item(it);
    end
    send_item(make_op(FUNC_SEND));
    // empty payload, then the same line again
    it             = make_op(FUNC_SET_STATUS);
    it.status_code = 8'h00;
    it.has_reason  = 1'b0;
    send_item(it);
    send_item(make_op(FUNC_SEND));
    send_item(make_op(FUNC_SEND));
  endtask

  task automatic test_store_full();
    item_t it;
    drain_line_bytes();
    cfg_write(REG_OVF_REASON, 8'hFF);
    it             = make_op(FUNC_SET_STATUS);
    it.status_code = 8'h41;
    it.has_reason  = 1'b1;
    send_item(it);
    repeat (6) begin
      it        = make_op(FUNC_APPEND_NUM);
      it.number = 16'hFFFF;
      send_item(it);
    end
    send_item(make_op(FUNC_APPEND_BYTE));
    // payload exactly full: longest line
    send_item(make_op(FUNC_SEND));
    it        = make_op(FUNC_APPEND_NUM);
    it.number = 16'hFFFF;
    send_item(it);
    send_item(make_op(FUNC_SEND));
  endtask

  task automatic test_config_settings();
    logic [7:0] bug_vals    [4];
    logic [7:0] ovf_vals    [4];
    logic [7:0] uninit_vals [4];
    bug_vals    = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    ovf_vals    = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
    uninit_vals = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    foreach (bug_vals[k]) begin
      drain_line_bytes();
      cfg_write(REG_BUG_STATUS, bug_vals[k]);
      cfg_write(REG_OVF_REASON, ovf_vals[k]);
      cfg_write(REG_UNINIT_REASON, uninit_vals[k]);
      cfg_write(REG_UNMAPPED, 8'($urandom));
      idle_en = 1'b1;
      random_lines(30);
    end
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b0;
    random_lines(120);
    // hold off until the whole backlog is out
    drain_line_bytes();
    idle_en = 1'b1;
    random_lines(240);
  endtask

  initial begin
    start             = 1'b0;
    item_i            = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    idle_en           = 1'b0;
    cfg_bug_status    = BUG_STATUS_RST;
    cfg_ovf_reason    = OVF_REASON_RST;
    cfg_uninit_reason = UNINIT_REASON_RST;
    line_status       = BUG_STATUS_RST;
    foreach (line_payload[k]) line_payload[k] = '0;
    line_payload[0]   = UNINIT_REASON_RST;
    line_len          = 1;
    line_fresh        = 1'b1;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fresh_line();
    test_each_operation();
    test_store_full();
    test_config_settings();
    test_random_traffic();
    drain_line_bytes();

    if (error_cnt == 0 && line_bytes_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
